### design/bqc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bqc_pkg;

  localparam int MAX_SECTIONS_DEF = 4;
  localparam int SAMPLE_WIDTH_DEF = 24;

  localparam int COEF_W    = 32;
  localparam int STATE_W   = 40;
  localparam int COEF_FRAC = 29;
  localparam int SPLIT     = STATE_W / 2;
  localparam int MUL_W     = COEF_W + SPLIT + 1;
  localparam int FULL_W    = COEF_W + STATE_W;
  localparam int PROD_W    = FULL_W - COEF_FRAC;
  localparam int ACC_W     = PROD_W + 2;
  localparam int SLOTS     = 7;

  localparam int IN_FIXED_W = 2 + 3 + COEF_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_ACTIVE_SECTIONS = 1'b0;
  localparam logic [2:0] ACTIVE_RESET = 3'd4;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_PRIME  = 2'd1,
    OP_FILTER = 2'd2
  } op_t;

  typedef struct packed {
    logic                      start;
    logic signed [COEF_W-1:0]  coef;
    logic signed [STATE_W-1:0] opnd;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

`default_nettype wire

### design/bqc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bqc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 28
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/bqc_rmul.sv
`timescale 1ns / 1ps
`default_nettype none

module bqc_rmul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bqc_pkg::mul_req_t req,
  output bqc_pkg::mul_rsp_t      rsp
);

  logic [3:0] pipe_r;
  logic signed [bqc_pkg::COEF_W-1:0]  coef_r;
  logic signed [bqc_pkg::STATE_W-1:0] opnd_r;
  logic signed [bqc_pkg::SPLIT:0]     mb;
  logic signed [bqc_pkg::MUL_W-1:0]   mul_r;
  logic signed [bqc_pkg::MUL_W-1:0]   lo_r;
  logic        [bqc_pkg::FULL_W-1:0]  full;
  logic signed [bqc_pkg::PROD_W-1:0]  prod_r;

  // low half as unsigned, high half signed
  assign mb = pipe_r[0] ? {1'b0, opnd_r[bqc_pkg::SPLIT-1:0]}
                        : {opnd_r[bqc_pkg::STATE_W-1],
                           opnd_r[bqc_pkg::STATE_W-1:bqc_pkg::SPLIT]};

  assign full = {mul_r[bqc_pkg::FULL_W-bqc_pkg::SPLIT-1:0], {bqc_pkg::SPLIT{1'b0}}}
              + {{(bqc_pkg::FULL_W-bqc_pkg::MUL_W){lo_r[bqc_pkg::MUL_W-1]}}, lo_r}
              + (bqc_pkg::FULL_W'(1) << (bqc_pkg::COEF_FRAC - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r <= '0;
    end else begin
      pipe_r <= {pipe_r[2:0], req.start};
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      coef_r <= req.coef;
      opnd_r <= req.opnd;
    end
    if (pipe_r[0] || pipe_r[1]) begin
      mul_r <= coef_r * mb;
    end
    if (pipe_r[1]) begin
      lo_r <= mul_r;
    end
    if (pipe_r[2]) begin
      prod_r <= full[bqc_pkg::FULL_W-1:bqc_pkg::COEF_FRAC];
    end
  end

  assign rsp.done = pipe_r[3];
  assign rsp.prod = prod_r;

endmodule

`default_nettype wire

### design/biquad_cascade_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Cascade of up to MAX_SECTIONS second-order IIR sections (transposed direct
// form II) around one shared 32x21 multiplier that makes each rounded
// coefficient product in two passes. Coefficients and initial values sit in
// one RAM, delay words in a second. A load to a valid slot is written as it
// is taken; a prime fills both delay words of all MAX_SECTIONS sections; a
// filter sample runs the five products of each of N active sections in turn
// and goes straight to output when N is zero. One item is in work at a time;
// a finished result waits in the output register while the next is taken.
module biquad_cascade_filter_top #(
  parameter int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF,
  parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // section_index, slot_index, table_word, sample_in
  input  wire logic [((bqc_pkg::IN_FIXED_W + SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // opcode
  input  wire logic [1:0] in_tuser,
  output logic out_tvalid,
  input  wire logic out_tready,
  // sample_out
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  // saturated
  output logic out_tuser,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [bqc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [bqc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bqc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic cfg_pready
);

  localparam int SW        = SAMPLE_WIDTH;
  localparam int OUT_W     = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int TAB_DEPTH = MAX_SECTIONS * bqc_pkg::SLOTS;
  localparam int TA_W      = $clog2(TAB_DEPTH);
  localparam int DLY_DEPTH = 2 * MAX_SECTIONS;
  localparam int DA_W      = $clog2(DLY_DEPTH);
  localparam int SEC_W     = $clog2(MAX_SECTIONS + 1);
  localparam int SW_      = bqc_pkg::STATE_W;
  localparam int AW_      = bqc_pkg::ACC_W;
  localparam int PW_      = bqc_pkg::PROD_W;
  localparam int WORD_LSB  = 5;
  localparam int SMP_LSB   = bqc_pkg::IN_FIXED_W;

  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;
  localparam logic [2:0] SLOT_I0 = 3'd5;
  localparam logic [2:0] SLOT_I1 = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL,
    ST_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    STEP_B0,
    STEP_B1,
    STEP_A1,
    STEP_B2,
    STEP_A2,
    STEP_P5,
    STEP_P6
  } step_t;

  typedef struct packed {
    logic [2:0] slot;
    logic       dbit;
    logic       use_y;
    logic       pre_dly;
    logic       pre_zero;
    logic       neg;
  } step_ctl_t;

  function automatic logic [SW_-1:0] sat_state(input logic [AW_-1:0] s);
    logic [AW_-SW_:0] hi;
    hi = s[AW_-1:SW_-1];
    if ((&hi) || !(|hi)) begin
      return s[SW_-1:0];
    end else if (s[AW_-1]) begin
      return {1'b1, {(SW_-1){1'b0}}};
    end else begin
      return {1'b0, {(SW_-1){1'b1}}};
    end
  endfunction

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  step_ctl_t ctl;
  logic [SEC_W-1:0] sec_r, sec_nxt, n_r, n_nxt, n_sel, sec_inc;
  logic signed [SW_-1:0] v_r, v_nxt, y_r, y_nxt;
  logic signed [AW_-1:0] acc_r, acc_nxt;
  logic out_tvalid_r, out_tvalid_nxt;
  logic [SW-1:0] out_data_r, out_data_nxt;
  logic out_sat_r, out_sat_nxt;
  logic [2:0] active_r;
  logic [DLY_DEPTH-1:0] dvalid_r;
  logic dval_rd_r;

  logic in_xfer, cfg_wr;
  logic [1:0] in_sec;
  logic [2:0] in_slot;
  logic [bqc_pkg::COEF_W-1:0] in_word;
  logic [SW-1:0] in_sample;
  bqc_pkg::op_t in_op;
  logic [SW_-1:0] x_ext;

  logic tab_we;
  logic [TA_W-1:0] tab_waddr, tab_raddr;
  logic [bqc_pkg::COEF_W-1:0] tab_rdata;
  logic dly_we;
  logic [DA_W-1:0] dly_addr;
  logic [SW_-1:0] dly_rdata, dly_val;

  bqc_pkg::mul_req_t mul_req;
  bqc_pkg::mul_rsp_t mul_rsp;
  logic [AW_-1:0] prod_ext, sum;
  logic [SW_-1:0] sum_sat;

  logic [SW_-SW:0] clip_hi;
  logic in_range;
  logic [SW-1:0] out_val;

  assign in_xfer   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_sec    = in_tdata[1:0];
  assign in_slot   = in_tdata[4:2];
  assign in_word   = in_tdata[WORD_LSB +: bqc_pkg::COEF_W];
  assign in_sample = in_tdata[SMP_LSB +: SW];
  assign in_op     = bqc_pkg::op_t'(in_tuser);
  assign x_ext     = {{(SW_-SW){in_sample[SW-1]}}, in_sample};

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                  && (cfg_paddr[bqc_pkg::CFG_ADDR_W-1:2] == bqc_pkg::REG_ACTIVE_SECTIONS);
  assign cfg_prdata = (cfg_paddr[bqc_pkg::CFG_ADDR_W-1:2] == bqc_pkg::REG_ACTIVE_SECTIONS)
                      ? bqc_pkg::CFG_DATA_W'(active_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= bqc_pkg::ACTIVE_RESET;
    end else if (cfg_wr) begin
      active_r <= cfg_pwdata[2:0];
    end
  end

  always_comb begin
    ctl = '0;
    unique case (step_r)
      STEP_B0: ctl = '{slot: SLOT_B0, dbit: 1'b0, use_y: 1'b0, pre_dly: 1'b1,
                       pre_zero: 1'b0, neg: 1'b0};
      STEP_B1: ctl = '{slot: SLOT_B1, dbit: 1'b1, use_y: 1'b0, pre_dly: 1'b1,
                       pre_zero: 1'b0, neg: 1'b0};
      STEP_A1: ctl = '{slot: SLOT_A1, dbit: 1'b0, use_y: 1'b1, pre_dly: 1'b0,
                       pre_zero: 1'b0, neg: 1'b1};
      STEP_B2: ctl = '{slot: SLOT_B2, dbit: 1'b1, use_y: 1'b0, pre_dly: 1'b0,
                       pre_zero: 1'b1, neg: 1'b0};
      STEP_A2: ctl = '{slot: SLOT_A2, dbit: 1'b1, use_y: 1'b1, pre_dly: 1'b0,
                       pre_zero: 1'b0, neg: 1'b1};
      STEP_P5: ctl = '{slot: SLOT_I0, dbit: 1'b0, use_y: 1'b0, pre_dly: 1'b0,
                       pre_zero: 1'b1, neg: 1'b0};
      STEP_P6: ctl = '{slot: SLOT_I1, dbit: 1'b1, use_y: 1'b0, pre_dly: 1'b0,
                       pre_zero: 1'b1, neg: 1'b0};
      default: ctl = '0;
    endcase
  end

  assign tab_we    = in_xfer && (in_op == bqc_pkg::OP_LOAD)
                     && (32'(in_slot) < bqc_pkg::SLOTS) && (32'(in_sec) < MAX_SECTIONS);
  assign tab_waddr = TA_W'(32'(in_sec) * bqc_pkg::SLOTS + 32'(in_slot));
  assign tab_raddr = TA_W'(32'(sec_r) * bqc_pkg::SLOTS + 32'(ctl.slot));
  assign dly_addr  = DA_W'({sec_r, ctl.dbit});

  bqc_ram #(
    .WIDTH(bqc_pkg::COEF_W),
    .DEPTH(TAB_DEPTH)
  ) u_tab_ram (
    .clk  (clk),
    .we   (tab_we),
    .waddr(tab_waddr),
    .wdata(in_word),
    .raddr(tab_raddr),
    .rdata(tab_rdata)
  );

  bqc_ram #(
    .WIDTH(SW_),
    .DEPTH(DLY_DEPTH)
  ) u_dly_ram (
    .clk  (clk),
    .we   (dly_we),
    .waddr(dly_addr),
    .wdata(sum_sat),
    .raddr(dly_addr),
    .rdata(dly_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid_r  <= '0;
      dval_rd_r <= 1'b0;
    end else begin
      if (dly_we) begin
        dvalid_r[dly_addr] <= 1'b1;
      end
      dval_rd_r <= dvalid_r[dly_addr];
    end
  end

  assign dly_val = dval_rd_r ? dly_rdata : '0;

  assign mul_req.start = (state_r == ST_MUL);
  assign mul_req.coef  = tab_rdata;
  assign mul_req.opnd  = ctl.use_y ? y_r : v_r;

  bqc_rmul u_rmul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .rsp  (mul_rsp)
  );

  assign prod_ext = {{(AW_-PW_){mul_rsp.prod[PW_-1]}}, mul_rsp.prod};
  assign sum      = ctl.neg ? (acc_r - prod_ext) : (acc_r + prod_ext);
  assign sum_sat  = sat_state(sum);

  assign n_sel   = (32'(active_r) > MAX_SECTIONS) ? SEC_W'(MAX_SECTIONS) : SEC_W'(active_r);
  assign sec_inc = SEC_W'(sec_r + 1'b1);

  assign clip_hi  = v_r[SW_-1:SW-1];
  assign in_range = (&clip_hi) || !(|clip_hi);
  assign out_val  = in_range ? v_r[SW-1:0]
                  : (v_r[SW_-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    sec_nxt        = sec_r;
    n_nxt          = n_r;
    v_nxt          = v_r;
    y_nxt          = y_r;
    acc_nxt        = acc_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_sat_nxt    = out_sat_r;
    dly_we         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_op)
            bqc_pkg::OP_PRIME: begin
              v_nxt     = x_ext;
              sec_nxt   = '0;
              step_nxt  = STEP_P5;
              state_nxt = ST_RD;
            end
            bqc_pkg::OP_FILTER: begin
              v_nxt     = x_ext;
              sec_nxt   = '0;
              n_nxt     = n_sel;
              step_nxt  = STEP_B0;
              state_nxt = (n_sel == '0) ? ST_OUT : ST_RD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (ctl.pre_dly) begin
          acc_nxt = {{(AW_-SW_){dly_val[SW_-1]}}, dly_val};
        end else if (ctl.pre_zero) begin
          acc_nxt = '0;
        end
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = ST_RD;
          unique case (step_r)
            STEP_B0: begin
              y_nxt    = sum_sat;
              step_nxt = STEP_B1;
            end
            STEP_B1: begin
              acc_nxt  = sum;
              step_nxt = STEP_A1;
            end
            STEP_A1: begin
              dly_we   = 1'b1;
              step_nxt = STEP_B2;
            end
            STEP_B2: begin
              acc_nxt  = sum;
              step_nxt = STEP_A2;
            end
            STEP_A2: begin
              dly_we   = 1'b1;
              v_nxt    = y_r;
              sec_nxt  = sec_inc;
              step_nxt = STEP_B0;
              if (sec_inc == n_r) begin
                state_nxt = ST_OUT;
              end
            end
            STEP_P5: begin
              dly_we   = 1'b1;
              step_nxt = STEP_P6;
            end
            STEP_P6: begin
              dly_we   = 1'b1;
              sec_nxt  = sec_inc;
              step_nxt = STEP_P5;
              if (sec_inc == SEC_W'(MAX_SECTIONS)) begin
                state_nxt = ST_IDLE;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = out_val;
          out_sat_nxt    = !in_range;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= STEP_B0;
      sec_r        <= '0;
      n_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      sec_r        <= sec_nxt;
      n_r          <= n_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      v_r          <= v_nxt;
      y_r          <= y_nxt;
      acc_r        <= acc_nxt;
      out_data_r   <= out_data_nxt;
      out_sat_r    <= out_sat_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'(out_data_r);
  assign out_tuser  = out_sat_r;

endmodule

`default_nettype wire

### design/bqc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bqc_checker #(
  parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic [1:0] in_tuser,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  input wire logic out_tuser,
  input wire logic cfg_psel,
  input wire logic cfg_penable,
  input wire logic cfg_pwrite,
  input wire logic [bqc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input wire logic [bqc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input wire logic [bqc_pkg::CFG_DATA_W-1:0] cfg_prdata
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int AH = bqc_pkg::CFG_ADDR_W - 1;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != bqc_pkg::OP_FILTER) && !out_tvalid
    |=> !out_tvalid)
    else $error("result from a non-filter transfer");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready
    && ((in_tuser == bqc_pkg::OP_PRIME) || (in_tuser == bqc_pkg::OP_FILTER))
    |=> !in_tready)
    else $error("input taken while an item is in work");

  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser
    |-> (out_tdata[SW-1:0] == {1'b0, {(SW-1){1'b1}}})
        || (out_tdata[SW-1:0] == {1'b1, {(SW-1){1'b0}}}))
    else $error("saturated flag on an unclipped sample");

  a_cfg_read: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite
    && (cfg_paddr[AH:2] == bqc_pkg::REG_ACTIVE_SECTIONS)
    |=> (cfg_paddr[AH:2] != bqc_pkg::REG_ACTIVE_SECTIONS)
        || (cfg_prdata[2:0] == $past(cfg_pwdata[2:0])))
    else $error("register readback mismatch");

endmodule

bind biquad_cascade_filter_top bqc_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_bqc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_psel   (cfg_psel),
  .cfg_penable(cfg_penable),
  .cfg_pwrite (cfg_pwrite),
  .cfg_paddr  (cfg_paddr),
  .cfg_pwdata (cfg_pwdata),
  .cfg_prdata (cfg_prdata)
);

`default_nettype wire

### bench/biquad_tb_pkg.sv
`timescale 1ns / 1ps

package biquad_tb_pkg;

  localparam logic [2:0] SLOT_B0    = 3'd0;
  localparam logic [2:0] SLOT_B1    = 3'd1;
  localparam logic [2:0] SLOT_B2    = 3'd2;
  localparam logic [2:0] SLOT_A1    = 3'd3;
  localparam logic [2:0] SLOT_A2    = 3'd4;
  localparam logic [2:0] SLOT_INIT0 = 3'd5;
  localparam logic [2:0] SLOT_INIT1 = 3'd6;
  localparam logic [2:0] SLOT_NONE  = 3'd7;

  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam logic [bqc_pkg::CFG_ADDR_W-1:0] ADDR_ACTIVE_SECTIONS =
    {bqc_pkg::REG_ACTIVE_SECTIONS, 2'b00};

endpackage

### bench/biquad_cascade_filter_checker.sv
`timescale 1ns / 1ps

module biquad_cascade_filter_checker #(
  parameter int MAX_SEC  = bqc_pkg::MAX_SECTIONS_DEF,
  parameter int SAMPLE_W = bqc_pkg::SAMPLE_WIDTH_DEF,
  parameter int IN_W     = ((bqc_pkg::IN_FIXED_W + SAMPLE_W + 7) / 8) * 8,
  parameter int OUT_W    = ((SAMPLE_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,
  input  logic [1:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [OUT_W-1:0]                out_tdata,
  input  logic                            out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bqc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [bqc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  input  logic [bqc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  input  logic                            cfg_pready,
  output int                              fail_count,
  output int                              outstanding
);
  import bqc_pkg::*;
  import biquad_tb_pkg::*;

  localparam int TAB_DEPTH = MAX_SEC * SLOTS;
  localparam int SEC_LSB   = 0;
  localparam int SLOT_LSB  = 2;
  localparam int WORD_LSB  = 5;
  localparam int SMP_LSB   = WORD_LSB + COEF_W;

  localparam logic signed [63:0] STATE_HI = (64'sd1 <<< (STATE_W - 1)) - 64'sd1;
  localparam logic signed [63:0] STATE_LO = -(64'sd1 <<< (STATE_W - 1));
  localparam logic signed [63:0] OUT_HI   = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_LO   = -(64'sd1 <<< (SAMPLE_W - 1));

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                clipped;
  } filt_out_t;

  logic signed [COEF_W-1:0]  coef_tab [TAB_DEPTH];
  logic signed [STATE_W-1:0] delay_line [2*MAX_SEC];
  logic [2:0]                sections_cfg;
  filt_out_t                 filt_due [$];
  filt_out_t                 filt_head;
  int                        mismatch_total = 0;
  int                        due_depth = 0;

  assign fail_count  = mismatch_total;
  assign outstanding = due_depth;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_total++;
  endtask

  function automatic logic signed [63:0] coef_mul(input logic signed [COEF_W-1:0] c,
                                                  input logic signed [63:0] v);
    logic signed [127:0] p;
    p = c * v + (128'sd1 <<< (COEF_FRAC - 1));
    p = p >>> COEF_FRAC;
    return p[63:0];
  endfunction

  function automatic logic signed [STATE_W-1:0] clamp_state(input logic signed [63:0] v);
    if (v > STATE_HI) v = STATE_HI;
    else if (v < STATE_LO) v = STATE_LO;
    return v[STATE_W-1:0];
  endfunction

  task automatic apply_item(input logic [1:0] op, input logic [1:0] sec,
                            input logic [2:0] slot, input logic signed [COEF_W-1:0] word,
                            input logic signed [SAMPLE_W-1:0] smp);
    int                        k;
    int                        n;
    int                        base;
    logic signed [63:0]        v;
    logic signed [STATE_W-1:0] y_st;
    filt_out_t                 res;
    case (op)
      OP_LOAD: begin
        if (slot != SLOT_NONE && int'(sec) < MAX_SEC)
          coef_tab[int'(sec) * SLOTS + int'(slot)] = word;
      end
      OP_PRIME: begin
        for (k = 0; k < MAX_SEC; k++) begin
          base = k * SLOTS;
          delay_line[2*k]   = clamp_state(coef_mul(coef_tab[base + int'(SLOT_INIT0)], smp));
          delay_line[2*k+1] = clamp_state(coef_mul(coef_tab[base + int'(SLOT_INIT1)], smp));
        end
      end
      OP_FILTER: begin
        n = (int'(sections_cfg) > MAX_SEC) ? MAX_SEC : int'(sections_cfg);
        v = smp;
        for (k = 0; k < n; k++) begin
          base = k * SLOTS;
          y_st = clamp_state(coef_mul(coef_tab[base + int'(SLOT_B0)], v) + delay_line[2*k]);
          delay_line[2*k] = clamp_state(coef_mul(coef_tab[base + int'(SLOT_B1)], v)
                                        - coef_mul(coef_tab[base + int'(SLOT_A1)], y_st)
                                        + delay_line[2*k+1]);
          delay_line[2*k+1] = clamp_state(coef_mul(coef_tab[base + int'(SLOT_B2)], v)
                                          - coef_mul(coef_tab[base + int'(SLOT_A2)], y_st));
          v = y_st;
        end
        res.clipped = 1'b0;
        if (v > OUT_HI) begin
          v = OUT_HI;
          res.clipped = 1'b1;
        end else if (v < OUT_LO) begin
          v = OUT_LO;
          res.clipped = 1'b1;
        end
        res.sample = v[SAMPLE_W-1:0];
        filt_due.push_back(res);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (coef_tab[i]) coef_tab[i] = '0;
      foreach (delay_line[i]) delay_line[i] = '0;
      sections_cfg = ACTIVE_RESET;
      filt_due.delete();
      due_depth <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == ADDR_ACTIVE_SECTIONS) begin
        if (cfg_pwrite) begin
          sections_cfg = cfg_pwdata[2:0];
        end else if (cfg_prdata !== CFG_DATA_W'(sections_cfg)) begin
          report_mismatch($sformatf("active_sections read %0d, expected %0d",
                                    cfg_prdata, sections_cfg));
        end
      end
      if (out_tvalid && out_tready) begin
        if (filt_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, sample_out %0h",
                                    out_tdata));
        end else begin
          filt_head = filt_due.pop_front();
          if (out_tdata[SAMPLE_W-1:0] !== filt_head.sample)
            report_mismatch($sformatf("sample_out %0h, expected %0h",
                                      out_tdata[SAMPLE_W-1:0], filt_head.sample));
          if (out_tuser !== filt_head.clipped)
            report_mismatch($sformatf("saturated %0b, expected %0b",
                                      out_tuser, filt_head.clipped));
        end
      end
      if (in_tvalid && in_tready)
        apply_item(in_tuser, in_tdata[SEC_LSB +: 2], in_tdata[SLOT_LSB +: 3],
                   in_tdata[WORD_LSB +: COEF_W], in_tdata[SMP_LSB +: SAMPLE_W]);
      due_depth <= filt_due.size();
    end
  end

endmodule

### bench/tb_biquad_cascade_filter_top.sv
`timescale 1ns / 1ps

module tb_biquad_cascade_filter_top;
  import bqc_pkg::*;
  import biquad_tb_pkg::*;

  localparam int SAMPLE_W      = SAMPLE_WIDTH_DEF;
  localparam int MAX_SEC       = MAX_SECTIONS_DEF;
  localparam int IN_W          = ((IN_FIXED_W + SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_W         = ((SAMPLE_W + 7) / 8) * 8;
  localparam int IDLE_PCT      = 36;
  localparam int SETTLE_CYCLES = 12 * MAX_SEC + 16;
  localparam int PHASE_ITEMS   = 120;
  localparam int NUM_PHASES    = 10;
  localparam int QUIET_PHASE   = 4;
  localparam int TIMEOUT_NS    = 12_000_000;

  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] SMP_ZERO = '0;

  // active_sections per phase, phase 0 in the lowest bits
  localparam logic [3*NUM_PHASES-1:0] PHASE_SECTIONS =
    {3'd1, 3'd4, 3'd6, 3'd3, 3'd5, 3'd2, 3'd7, 3'd0, 3'd4, 3'd1};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  bit                    tx_pauses = 1'b1;
  bit                    rx_stalls = 1'b1;
  int                    fail_count;
  int                    outstanding;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= !rx_stalls || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  biquad_cascade_filter_top #(
    .MAX_SECTIONS(MAX_SEC),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  biquad_cascade_filter_checker #(
    .MAX_SEC (MAX_SEC),
    .SAMPLE_W(SAMPLE_W),
    .IN_W    (IN_W),
    .OUT_W   (OUT_W)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // leave tvalid high after the transfer; the next call pauses it or drives the next item, wait_quiet drops it
  task automatic send_item(input logic [1:0] op, input logic [1:0] sec, input logic [2:0] slot,
                           input logic [31:0] word, input logic [SAMPLE_W-1:0] smp);
    while (tx_pauses && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_W'({smp, word, slot, sec});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic filter_sample(input logic [SAMPLE_W-1:0] smp);
    send_item(OP_FILTER, 2'($urandom), 3'($urandom), $urandom, smp);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= wr;
    cfg_paddr  <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // hold off until every result is back and the last prime has had time to finish
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sections(input logic [2:0] n);
    wait_quiet();
    cfg_access(1'b1, ADDR_ACTIVE_SECTIONS, CFG_DATA_W'(n));
    cfg_access(1'b0, ADDR_ACTIVE_SECTIONS, '0);
  endtask

  function automatic logic [31:0] pick_word(input logic [2:0] slot, input bit wild);
    if (wild && $urandom_range(0, 3) == 0) return $urandom;
    case (slot)
      SLOT_A1: return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
      SLOT_A2: return $urandom_range(0, 32'h1800_0000);
      default: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(0, 1) == 0) return SAMPLE_W'($urandom);
    return SAMPLE_W'($urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
  endfunction

  task automatic load_stable_set();
    int sec;
    int slot;
    for (sec = 0; sec < MAX_SEC; sec++)
      for (slot = 0; slot <= int'(SLOT_INIT1); slot++)
        send_item(OP_LOAD, 2'(sec), 3'(slot), pick_word(3'(slot), 1'b0), pick_sample());
  endtask

  task automatic run_random(input int target);
    int         counted;
    int         r;
    logic [2:0] slot;
    counted = 0;
    while (counted < target) begin
      r    = $urandom_range(0, 99);
      slot = 3'($urandom_range(0, int'(SLOT_INIT1)));
      if (r < 60) begin
        filter_sample(pick_sample());
        counted++;
      end else if (r < 68) begin
        send_item(OP_PRIME, 2'($urandom), 3'($urandom), $urandom, pick_sample());
        counted++;
      end else if (r < 90) begin
        send_item(OP_LOAD, 2'($urandom), slot, pick_word(slot, 1'b1), SAMPLE_W'($urandom));
        counted++;
      end else if (r < 95) begin
        send_item(OP_LOAD, 2'($urandom), SLOT_NONE, $urandom, SAMPLE_W'($urandom));
      end else begin
        send_item(OP_IGNORED, 2'($urandom), 3'($urandom), $urandom, SAMPLE_W'($urandom));
      end
    end
  endtask

  initial begin
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_sections(3'd4);
    load_stable_set();

    filter_sample(SMP_ZERO);
    filter_sample(SMP_MAX);
    filter_sample(SMP_MIN);
    send_item(OP_PRIME, 2'd0, SLOT_B0, '0, SMP_MAX);
    filter_sample(pick_sample());
    send_item(OP_PRIME, 2'd0, SLOT_B0, '0, SMP_MIN);
    filter_sample(SMP_ZERO);
    send_item(OP_LOAD, 2'd0, SLOT_NONE, WORD_MAX, SMP_MAX);
    send_item(OP_IGNORED, 2'd3, SLOT_B0, WORD_MIN, SMP_MAX);
    filter_sample(SMP_MAX);
    send_item(OP_LOAD, 2'd0, SLOT_B0, WORD_MAX, SMP_ZERO);
    filter_sample(SMP_MAX);
    filter_sample(SMP_MIN);
    send_item(OP_LOAD, 2'd0, SLOT_B0, WORD_MIN, SMP_ZERO);
    filter_sample(SMP_MAX);
    filter_sample(SMP_MIN);
    send_item(OP_LOAD, 2'd3, SLOT_INIT1, WORD_MIN, SMP_ZERO);
    send_item(OP_PRIME, 2'd0, SLOT_B0, '0, SMP_MIN);
    filter_sample(SMP_MIN);
    set_sections(3'd0);
    filter_sample(SMP_MAX);
    filter_sample(SMP_MIN);
    set_sections(3'd7);
    filter_sample(SMP_MAX);
    set_sections(3'd1);
    filter_sample(SMP_MIN);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      set_sections(PHASE_SECTIONS[3*phase +: 3]);
      tx_pauses = (phase != QUIET_PHASE);
      rx_stalls <= (phase != QUIET_PHASE);
      if (phase % 2 == 0) load_stable_set();
      run_random(PHASE_ITEMS);
    end

    wait_quiet();
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule

### biquad_cascade_filter_top.f
design/bqc_pkg.sv
design/bqc_ram.sv
design/bqc_rmul.sv
design/biquad_cascade_filter_top.sv
design/bqc_checker.sv
bench/biquad_tb_pkg.sv
bench/biquad_cascade_filter_checker.sv
bench/tb_biquad_cascade_filter_top.sv
